// ----- design/bqf_pkg.sv -----
`timescale 1ns / 1ps

package bqf_pkg;

    localparam int SAMPLE_WIDTH    = 24;
    localparam int COEFF_FRAC_BITS = 24;
    localparam int COEFF_WIDTH     = 32;
    localparam int MID_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int STEP_WIDTH      = 4;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FF_GAIN_0 = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FF_GAIN_1 = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FF_GAIN_2 = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUT_SCALE = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FB_GAIN_1 = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FB_GAIN_2 = 3'd5;

    typedef logic [STEP_WIDTH-1:0] step_t;

    // wait conditions: COND_NEXT steps on; COND_IN and COND_OUT stay on the step until the condition holds, then jump
    typedef enum logic [1:0] {
        COND_NEXT,
        COND_IN,
        COND_OUT
    } cond_t;

    typedef enum logic [2:0] {
        COEF_FF0,
        COEF_FF1,
        COEF_FF2,
        COEF_FB1,
        COEF_FB2,
        COEF_SCALE
    } coef_sel_t;

    typedef enum logic [2:0] {
        OPB_X0,
        OPB_X1,
        OPB_X2,
        OPB_Y1,
        OPB_Y2,
        OPB_MID
    } opb_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        cond_t     cond;
        step_t     jmp;
        coef_sel_t coef_sel;
        opb_sel_t  opb_sel;
        logic      mul_en;
        acc_op_t   acc_op;
        logic      x_load;
        logic      mid_load;
        logic      out_load;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } seq_flags_t;

    typedef struct packed {
        logic signed [COEFF_WIDTH-1:0] ff_gain_0;
        logic signed [COEFF_WIDTH-1:0] ff_gain_1;
        logic signed [COEFF_WIDTH-1:0] ff_gain_2;
        logic signed [COEFF_WIDTH-1:0] out_scale;
        logic signed [COEFF_WIDTH-1:0] fb_gain_1;
        logic signed [COEFF_WIDTH-1:0] fb_gain_2;
    } coeffs_t;

    // microcode: one control word per step
    function automatic ctrl_t ucode(step_t step);
        ctrl_t w;
        w = '{COND_NEXT, step_t'(0), COEF_FF0, OPB_X0, 1'b0, ACC_HOLD, 1'b0, 1'b0, 1'b0};
        case (step)
            step_t'(0):
            begin
                w.cond   = COND_IN;
                w.jmp    = step_t'(1);
                w.x_load = 1'b1;
            end
            step_t'(1):
            begin
                w.coef_sel = COEF_FF0;
                w.opb_sel  = OPB_X0;
                w.mul_en   = 1'b1;
            end
            step_t'(2):
            begin
                w.coef_sel = COEF_FF1;
                w.opb_sel  = OPB_X1;
                w.mul_en   = 1'b1;
                w.acc_op   = ACC_LOAD;
            end
            step_t'(3):
            begin
                w.coef_sel = COEF_FF2;
                w.opb_sel  = OPB_X2;
                w.mul_en   = 1'b1;
                w.acc_op   = ACC_ADD;
            end
            step_t'(4):
            begin
                w.coef_sel = COEF_FB1;
                w.opb_sel  = OPB_Y1;
                w.mul_en   = 1'b1;
                w.acc_op   = ACC_ADD;
            end
            step_t'(5):
            begin
                w.coef_sel = COEF_FB2;
                w.opb_sel  = OPB_Y2;
                w.mul_en   = 1'b1;
                w.acc_op   = ACC_ADD;
            end
            step_t'(6):
            begin
                w.acc_op = ACC_ADD;
            end
            step_t'(7):
            begin
                w.mid_load = 1'b1;
            end
            step_t'(8):
            begin
                w.coef_sel = COEF_SCALE;
                w.opb_sel  = OPB_MID;
                w.mul_en   = 1'b1;
            end
            step_t'(9):
            begin
                w.acc_op = ACC_LOAD;
            end
            step_t'(10):
            begin
                w.cond     = COND_OUT;
                w.jmp      = step_t'(0);
                w.out_load = 1'b1;
            end
            default:
            begin
                w.cond = COND_NEXT;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- design/bqf_sequencer.sv -----
`timescale 1ns / 1ps

module bqf_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  bqf_pkg::seq_flags_t flags,
    output bqf_pkg::ctrl_t     ctrl
);

    bqf_pkg::step_t step_reg;
    bqf_pkg::step_t step_next;

    always_comb
    begin
        ctrl = bqf_pkg::ucode(step_reg);
    end

    always_comb
    begin
        unique case (ctrl.cond)
            bqf_pkg::COND_NEXT: step_next = step_reg + bqf_pkg::step_t'(1);
            bqf_pkg::COND_IN:   step_next = flags.in_valid ? ctrl.jmp : step_reg;
            bqf_pkg::COND_OUT:  step_next = flags.out_free ? ctrl.jmp : step_reg;
            default:            step_next = step_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- design/bqf_datapath.sv -----
`timescale 1ns / 1ps

module bqf_datapath #(
    parameter int SAMPLE_WIDTH    = bqf_pkg::SAMPLE_WIDTH,
    parameter int COEFF_FRAC_BITS = bqf_pkg::COEFF_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bqf_pkg::ctrl_t                 ctrl,
    input  logic                           commit,
    input  bqf_pkg::coeffs_t               coeffs,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic signed [SAMPLE_WIDTH-1:0] y_out
);

    localparam int CW = bqf_pkg::COEFF_WIDTH;
    localparam int MW = bqf_pkg::MID_WIDTH;
    localparam int PW = 2 * CW;
    localparam int AW = PW + 2;

    localparam logic signed [AW-1:0] RND_HALF = AW'(1) <<< (COEFF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] MID_MAX  = (AW'(1) <<< (MW - 1)) - AW'(1);
    localparam logic signed [AW-1:0] MID_MIN  = -MID_MAX - AW'(1);
    localparam logic signed [AW-1:0] OUT_MAX  = (AW'(1) <<< (SAMPLE_WIDTH - 1)) - AW'(1);
    localparam logic signed [AW-1:0] OUT_MIN  = -OUT_MAX - AW'(1);

    logic signed [SAMPLE_WIDTH-1:0] x0_reg;
    logic signed [SAMPLE_WIDTH-1:0] x1_reg;
    logic signed [SAMPLE_WIDTH-1:0] x2_reg;
    logic signed [SAMPLE_WIDTH-1:0] y1_reg;
    logic signed [SAMPLE_WIDTH-1:0] y2_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_next;
    logic signed [MW-1:0]           mid_reg;
    logic signed [MW-1:0]           mid_next;
    logic signed [PW-1:0]           prod_reg;
    logic signed [AW-1:0]           acc_reg;
    logic signed [AW-1:0]           acc_next;
    logic signed [AW-1:0]           acc_shift;
    logic signed [CW-1:0]           a_op;
    logic signed [CW-1:0]           b_op;

    always_comb
    begin
        case (ctrl.coef_sel)
            bqf_pkg::COEF_FF0: a_op = coeffs.ff_gain_0;
            bqf_pkg::COEF_FF1: a_op = coeffs.ff_gain_1;
            bqf_pkg::COEF_FF2: a_op = coeffs.ff_gain_2;
            bqf_pkg::COEF_FB1: a_op = coeffs.fb_gain_1;
            bqf_pkg::COEF_FB2: a_op = coeffs.fb_gain_2;
            default:           a_op = coeffs.out_scale;
        endcase
    end

    always_comb
    begin
        case (ctrl.opb_sel)
            bqf_pkg::OPB_X0: b_op = CW'(x0_reg);
            bqf_pkg::OPB_X1: b_op = CW'(x1_reg);
            bqf_pkg::OPB_X2: b_op = CW'(x2_reg);
            bqf_pkg::OPB_Y1: b_op = CW'(y1_reg);
            bqf_pkg::OPB_Y2: b_op = CW'(y2_reg);
            default:         b_op = CW'(mid_reg);
        endcase
    end

    // the round half is folded into the first add of each sum
    always_comb
    begin
        case (ctrl.acc_op)
            bqf_pkg::ACC_LOAD: acc_next = AW'(prod_reg) + RND_HALF;
            bqf_pkg::ACC_ADD:  acc_next = acc_reg + AW'(prod_reg);
            default:           acc_next = acc_reg;
        endcase
    end

    assign acc_shift = acc_reg >>> COEFF_FRAC_BITS;

    always_comb
    begin
        if (acc_shift > MID_MAX)
        begin
            mid_next = MW'(MID_MAX);
        end
        else if (acc_shift < MID_MIN)
        begin
            mid_next = MW'(MID_MIN);
        end
        else
        begin
            mid_next = MW'(acc_shift);
        end
    end

    always_comb
    begin
        if (acc_shift > OUT_MAX)
        begin
            y_next = SAMPLE_WIDTH'(OUT_MAX);
        end
        else if (acc_shift < OUT_MIN)
        begin
            y_next = SAMPLE_WIDTH'(OUT_MIN);
        end
        else
        begin
            y_next = SAMPLE_WIDTH'(acc_shift);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.x_load)
        begin
            x0_reg <= sample_in;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= PW'(a_op) * PW'(b_op);
        end
        acc_reg <= acc_next;
        if (ctrl.mid_load)
        begin
            mid_reg <= mid_next;
        end
        if (commit)
        begin
            y_reg <= y_next;
        end
    end

    // filter history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (commit)
        begin
            x1_reg <= x0_reg;
            x2_reg <= x1_reg;
            y1_reg <= y_next;
            y2_reg <= y1_reg;
        end
    end

    assign y_out = y_reg;

endmodule

// ----- design/peaking_biquad_iir_filter.sv -----
`timescale 1ns / 1ps

// Direct form I biquad: y = sat(round(sat32(round(ff0*x0 + ff1*x1 + ff2*x2 + fb1*y1 + fb2*y2))
// * out_scale)), coefficients signed with COEFF_FRAC_BITS fraction bits. The user must load them over
// the write port only while the filter is idle; the block itself does not enforce this. One shared
// 32x32 multiplier with a registered product feeding a wide accumulator is stepped by an eleven-step
// microprogram; a new input sample is taken only once the previous result has been committed to the
// output, and a stalled result holds the last step until it is taken. History and coefficients take
// their reset values at once.
module peaking_biquad_iir_filter #(
    parameter int SAMPLE_WIDTH    = bqf_pkg::SAMPLE_WIDTH,
    parameter int COEFF_FRAC_BITS = bqf_pkg::COEFF_FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
    input  logic                                  cfg_we,
    input  logic [bqf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [bqf_pkg::COEFF_WIDTH-1:0]       cfg_data
);

    localparam int CW = bqf_pkg::COEFF_WIDTH;
    localparam logic signed [CW-1:0] COEF_ONE = CW'(1) <<< COEFF_FRAC_BITS;

    bqf_pkg::ctrl_t      ctrl;
    bqf_pkg::seq_flags_t flags;
    bqf_pkg::coeffs_t    coeffs_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;
    logic                commit;

    assign out_free       = !out_valid_reg || !out_stall;
    assign commit         = ctrl.out_load && out_free;
    assign flags.in_valid = in_valid;
    assign flags.out_free = out_free;
    assign in_stall       = !ctrl.x_load;
    assign out_valid      = out_valid_reg;

    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeffs_reg.ff_gain_0 <= COEF_ONE;
            coeffs_reg.ff_gain_1 <= '0;
            coeffs_reg.ff_gain_2 <= '0;
            coeffs_reg.out_scale <= COEF_ONE;
            coeffs_reg.fb_gain_1 <= '0;
            coeffs_reg.fb_gain_2 <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bqf_pkg::REG_FF_GAIN_0: coeffs_reg.ff_gain_0 <= cfg_data;
                bqf_pkg::REG_FF_GAIN_1: coeffs_reg.ff_gain_1 <= cfg_data;
                bqf_pkg::REG_FF_GAIN_2: coeffs_reg.ff_gain_2 <= cfg_data;
                bqf_pkg::REG_OUT_SCALE: coeffs_reg.out_scale <= cfg_data;
                bqf_pkg::REG_FB_GAIN_1: coeffs_reg.fb_gain_1 <= cfg_data;
                bqf_pkg::REG_FB_GAIN_2: coeffs_reg.fb_gain_2 <= cfg_data;
                default:
                begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    bqf_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    bqf_datapath #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .commit    (commit),
        .coeffs    (coeffs_reg),
        .sample_in (sample_in),
        .y_out     (sample_out)
    );

endmodule
